// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the drive ramp block.
// Each use expands to one labeled concurrent assertion on a rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every edge outside reset.
`define DDRSP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ddrsp assertion failed");

// The expression must never be true outside reset.
`define DDRSP_NEVER(lbl, clk, rst, expr) \
   `DDRSP_ASSERT(lbl, clk, rst, !(expr))

`endif

// File: rtl/core/ddrsp_pkg.sv
// Package of the differential drive ramp and step period block.
// Holds field widths, opcodes, register indexes and reset values; depends on nothing.
package ddrsp_pkg;

   localparam int FRACTION_BITS = 8;

   localparam int OP_W       = 2;
   localparam int VAL_W      = 24;
   localparam int VEL_W      = VAL_W + 1;
   localparam int WHEEL_W    = VEL_W + 1;
   localparam int STEP_W     = 16;
   localparam int NUMER_W    = 30;
   localparam int LIMIT_W    = 31;
   localparam int PERIOD_W   = 32;
   localparam int CURV_SHIFT = 12;
   localparam int PROD_W     = 2 * VAL_W;

   localparam int DIVIDEND_W = NUMER_W + FRACTION_BITS;
   localparam int CNT_W      = $clog2(DIVIDEND_W);

   localparam int REQ_DATA_W = ((2 * VAL_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * PERIOD_W + 7) / 8) * 8;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = LIMIT_W;

   typedef enum logic [OP_W-1:0] {
      OP_TICK      = 2'd0,
      OP_SET_WHEEL = 2'd1,
      OP_SET_CURV  = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COMMON_STEP = 2'd0,
      CSR_DIFF_STEP   = 2'd1,
      CSR_NUMERATOR   = 2'd2,
      CSR_LIMIT       = 2'd3
   } csr_index_type;

   localparam logic [STEP_W-1:0]  RST_COMMON_STEP = 16'd13;
   localparam logic [STEP_W-1:0]  RST_DIFF_STEP   = 16'd205;
   localparam logic [NUMER_W-1:0] RST_NUMERATOR   = 30'd1000000000;
   localparam logic [LIMIT_W-1:0] RST_LIMIT       = 31'd5000000;

endpackage

// File: rtl/core/diff_drive_ramp_step_period.sv
// Top level of the differential drive ramp limiter with wheel step period output.
// Uses ddrsp_pkg and assert_macros.svh; multiply and divide run bit-serially.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tuser op, tdata value_a, value_b
//   rsp      out        rsp_tvalid/rsp_tready  tdata left_period, right_period
//   csr      in         csr_we                 csr_index, csr_wdata
//
// A wheel-speed set is applied when it is accepted. A curvature set is accepted, then runs
// one step per multiplier bit in the shift-add multiplier, then scales and saturates.
// A tick ramps, forms the wheel sums, loads, then runs 38 restoring divide steps
// (one per dividend bit, both wheels side by side) before its word is registered.
// The result register lets new items in while a word waits; a tick whose word
// cannot be stored holds in its last state. Reset is synchronous.
`include "assert_macros.svh"

module diff_drive_ramp_step_period (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // value_a [23:0], value_b [47:24]
   input  logic [ddrsp_pkg::REQ_DATA_W-1:0]     req_tdata,
   // op [1:0]
   input  logic [ddrsp_pkg::OP_W-1:0]           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // left_period [31:0], right_period [63:32]
   output logic [ddrsp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_we,
   input  logic [ddrsp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ddrsp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ddrsp_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_MUL_FIN,
      S_SUM,
      S_LOAD,
      S_DIV,
      S_DONE
   } state_type;

   localparam int LANES = 2;

   state_type                  state_ff;
   logic [CNT_W-1:0]           cnt_ff;

   logic [STEP_W-1:0]          common_step_ff;
   logic [STEP_W-1:0]          diff_step_ff;
   logic [NUMER_W-1:0]         numer_ff;
   logic [LIMIT_W-1:0]         limit_ff;

   logic signed [VEL_W-1:0]    tgt_common_ff;
   logic signed [VEL_W-1:0]    tgt_diff_ff;
   logic signed [VEL_W-1:0]    cur_common_ff;
   logic signed [VEL_W-1:0]    cur_diff_ff;

   logic [VAL_W-1:0]           mcand_ff;
   logic [PROD_W-1:0]          prod_ff;
   logic                       mul_neg_ff;

   logic signed [WHEEL_W-1:0]  vel_ff  [LANES];
   logic                       neg_ff  [LANES];
   logic [WHEEL_W-1:0]         div_ff  [LANES];
   logic [WHEEL_W:0]           rem_ff  [LANES];
   logic [DIVIDEND_W-1:0]      quo_ff  [LANES];

   logic                       rsp_tvalid_ff;
   logic [PERIOD_W-1:0]        rsp_left_ff;
   logic [PERIOD_W-1:0]        rsp_right_ff;

   logic                       accept;
   logic signed [VAL_W-1:0]    req_a;
   logic signed [VAL_W-1:0]    req_b;
   logic [VAL_W-1:0]           abs_a;
   logic [VAL_W-1:0]           abs_b;
   logic signed [VEL_W-1:0]    ab_sum;
   logic signed [VEL_W-1:0]    ab_dif;
   logic signed [VEL_W-1:0]    cur_common_in;
   logic signed [VEL_W-1:0]    cur_diff_in;
   logic [VAL_W:0]             mul_upper;
   logic [PROD_W-1:0]          prod_in;
   logic signed [PROD_W:0]     prod_signed;
   logic signed [PROD_W:0]     prod_scaled;
   logic [PROD_W-VEL_W+1:0]    prod_hi;
   logic signed [VEL_W-1:0]    curv_diff;
   logic [WHEEL_W:0]           part     [LANES];
   logic                       ge       [LANES];
   logic [WHEEL_W:0]           rem_in   [LANES];
   logic [DIVIDEND_W-1:0]      quo_in   [LANES];
   logic [PERIOD_W-1:0]        period   [LANES];
   logic                       rsp_free;
   logic                       div_live;
   logic                       rem_ok;
   logic                       done_stall;

   function automatic logic signed [VEL_W-1:0] ramp_f(
      input logic signed [VEL_W-1:0] cur,
      input logic signed [VEL_W-1:0] dst,
      input logic [STEP_W-1:0]       step
   );
      logic signed [VEL_W:0] cur_x;
      logic signed [VEL_W:0] dst_x;
      logic signed [VEL_W:0] step_x;
      logic signed [VEL_W:0] up;
      logic signed [VEL_W:0] dn;
      cur_x  = {cur[VEL_W-1], cur};
      dst_x  = {dst[VEL_W-1], dst};
      step_x = $signed({{(VEL_W + 1 - STEP_W){1'b0}}, step});
      up     = cur_x + step_x;
      dn     = cur_x - step_x;
      if (cur < dst) begin
         ramp_f = (up > dst_x) ? dst : up[VEL_W-1:0];
      end else if (cur > dst) begin
         ramp_f = (dn < dst_x) ? dst : dn[VEL_W-1:0];
      end else begin
         ramp_f = cur;
      end
   endfunction

   assign accept   = req_tvalid && req_tready;
   assign req_a    = $signed(req_tdata[VAL_W-1:0]);
   assign req_b    = $signed(req_tdata[2*VAL_W-1:VAL_W]);
   assign abs_a    = req_a[VAL_W-1] ? (VAL_W'(0) - req_a) : req_a;
   assign abs_b    = req_b[VAL_W-1] ? (VAL_W'(0) - req_b) : req_b;
   assign ab_sum   = {req_a[VAL_W-1], req_a} + {req_b[VAL_W-1], req_b};
   assign ab_dif   = {req_a[VAL_W-1], req_a} - {req_b[VAL_W-1], req_b};

   assign cur_common_in = ramp_f(cur_common_ff, tgt_common_ff, common_step_ff);
   assign cur_diff_in   = ramp_f(cur_diff_ff, tgt_diff_ff, diff_step_ff);

   // Shift-add multiplier: the low half holds the remaining multiplier bits.
   assign mul_upper = prod_ff[0] ? ({1'b0, prod_ff[PROD_W-1:VAL_W]} + {1'b0, mcand_ff})
                                 : {1'b0, prod_ff[PROD_W-1:VAL_W]};
   assign prod_in   = {mul_upper, prod_ff[VAL_W-1:1]};

   // Sign, arithmetic shift (floor) and saturation to the velocity range.
   assign prod_signed = mul_neg_ff ? -$signed({1'b0, prod_ff}) : $signed({1'b0, prod_ff});
   assign prod_scaled = prod_signed >>> CURV_SHIFT;
   assign prod_hi     = prod_scaled[PROD_W:VEL_W-1];
   always_comb begin
      if ((&prod_hi) || !(|prod_hi)) begin
         curv_diff = prod_scaled[VEL_W-1:0];
      end else if (prod_hi[PROD_W-VEL_W+1]) begin
         curv_diff = {1'b1, {(VEL_W-1){1'b0}}};
      end else begin
         curv_diff = {1'b0, {(VEL_W-1){1'b1}}};
      end
   end

   // One restoring divide step per lane, and the final period of each lane.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         part[i]   = {rem_ff[i][WHEEL_W-1:0], quo_ff[i][DIVIDEND_W-1]};
         ge[i]     = part[i] >= {1'b0, div_ff[i]};
         rem_in[i] = ge[i] ? (part[i] - {1'b0, div_ff[i]}) : part[i];
         quo_in[i] = {quo_ff[i][DIVIDEND_W-2:0], ge[i]};
         if (div_ff[i] == '0 || quo_ff[i] > DIVIDEND_W'(limit_ff)) begin
            period[i] = '0;
         end else if (neg_ff[i]) begin
            period[i] = PERIOD_W'(0) - quo_ff[i][PERIOD_W-1:0];
         end else begin
            period[i] = quo_ff[i][PERIOD_W-1:0];
         end
      end
   end

   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 2*PERIOD_W){1'b0}}, rsp_right_ff, rsp_left_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         common_step_ff <= RST_COMMON_STEP;
         diff_step_ff   <= RST_DIFF_STEP;
         numer_ff       <= RST_NUMERATOR;
         limit_ff       <= RST_LIMIT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COMMON_STEP: common_step_ff <= csr_wdata[STEP_W-1:0];
            CSR_DIFF_STEP:   diff_step_ff   <= csr_wdata[STEP_W-1:0];
            CSR_NUMERATOR:   numer_ff       <= csr_wdata[NUMER_W-1:0];
            CSR_LIMIT:       limit_ff       <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         tgt_common_ff <= '0;
         tgt_diff_ff   <= '0;
         cur_common_ff <= '0;
         cur_diff_ff   <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // A finished tick refills the register itself in the same cycle.
         if (rsp_tvalid_ff && rsp_tready && state_ff != S_DONE) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  case (req_tuser)
                     OP_TICK: begin
                        cur_common_ff <= cur_common_in;
                        cur_diff_ff   <= cur_diff_in;
                        state_ff      <= S_SUM;
                     end
                     OP_SET_WHEEL: begin
                        tgt_common_ff <= {ab_sum[VEL_W-1], ab_sum[VEL_W-1:1]};
                        tgt_diff_ff   <= {ab_dif[VEL_W-1], ab_dif[VEL_W-1:1]};
                     end
                     OP_SET_CURV: begin
                        tgt_common_ff <= {{(VEL_W-VAL_W){req_a[VAL_W-1]}}, req_a};
                        mcand_ff      <= abs_a;
                        prod_ff       <= {{(PROD_W-VAL_W){1'b0}}, abs_b};
                        mul_neg_ff    <= req_a[VAL_W-1] ^ req_b[VAL_W-1];
                        cnt_ff        <= '0;
                        state_ff      <= S_MUL;
                     end
                     default: ;
                  endcase
               end
            end
            S_MUL: begin
               prod_ff <= prod_in;
               cnt_ff  <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(VAL_W - 1)) begin
                  state_ff <= S_MUL_FIN;
               end
            end
            S_MUL_FIN: begin
               tgt_diff_ff <= curv_diff;
               state_ff    <= S_IDLE;
            end
            S_SUM: begin
               vel_ff[0] <= {cur_common_ff[VEL_W-1], cur_common_ff}
                          + {cur_diff_ff[VEL_W-1], cur_diff_ff};
               vel_ff[1] <= {cur_common_ff[VEL_W-1], cur_common_ff}
                          - {cur_diff_ff[VEL_W-1], cur_diff_ff};
               state_ff  <= S_LOAD;
            end
            S_LOAD: begin
               for (int i = 0; i < LANES; i++) begin
                  neg_ff[i] <= vel_ff[i][WHEEL_W-1];
                  div_ff[i] <= vel_ff[i][WHEEL_W-1] ? (WHEEL_W'(0) - vel_ff[i]) : vel_ff[i];
                  rem_ff[i] <= '0;
                  quo_ff[i] <= {numer_ff, {FRACTION_BITS{1'b0}}};
               end
               cnt_ff   <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               for (int i = 0; i < LANES; i++) begin
                  rem_ff[i] <= rem_in[i];
                  quo_ff[i] <= quo_in[i];
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_left_ff   <= period[0];
                  rsp_right_ff  <= period[1];
                  rsp_tvalid_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign div_live   = (state_ff == S_DIV) && (div_ff[0] != '0);
   assign rem_ok     = rem_ff[0] < {1'b0, div_ff[0]};
   assign done_stall = (state_ff == S_DONE) && rsp_tvalid_ff && !rsp_tready;

   // The partial remainder of lane 0 stays below a nonzero divisor on every step.
   `DDRSP_ASSERT(a_rem_below_div, clock, reset, div_live |-> rem_ok)
   // The step counter never runs past the dividend width.
   `DDRSP_NEVER(a_cnt_overrun, clock, reset, (state_ff == S_DIV && cnt_ff >= CNT_W'(DIVIDEND_W)))
   // A new word appears only when a finished tick hands it over.
   `DDRSP_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_tvalid_ff) |-> $past(state_ff == S_DONE))
   // A finished tick waits while an earlier word is still held.
   `DDRSP_ASSERT(a_done_holds, clock, reset, done_stall |=> (state_ff == S_DONE && $stable(rsp_tdata)))

endmodule

// File: tb/tb_diff_drive_ramp_step_period.sv
// Testbench of diff_drive_ramp_step_period: directed and random drive commands checked
// word by word against a behavioral model of the ramp limiter and the period divider.
// Depends on ddrsp_pkg and the RTL top level only.
module tb_diff_drive_ramp_step_period;
   timeunit 1ns;
   timeprecision 1ps;
   import ddrsp_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int     SETTLE_CYCLES = 60;
   localparam int     IDLE_PERCENT  = 21;
   localparam longint VEL_MAX       = 64'sd16777215;
   localparam longint VEL_MIN       = -64'sd16777216;
   localparam logic [VAL_W-1:0] VAL_MAX = 24'h7FFFFF;
   localparam logic [VAL_W-1:0] VAL_MIN = 24'h800000;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [VAL_W-1:0] value_a;
      logic [VAL_W-1:0] value_b;
   } drive_cmd_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] left_period;
      logic [PERIOD_W-1:0] right_period;
   } period_pair_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   logic req_fire = 1'b0;
   logic idle_en  = 1'b1;
   int   failures = 0;

   drive_cmd_type   pending_cmds[$];
   period_pair_type periods_due[$];

   // Register copies and velocity state of the behavioral model.
   logic [STEP_W-1:0]  m_common_step = RST_COMMON_STEP;
   logic [STEP_W-1:0]  m_diff_step   = RST_DIFF_STEP;
   logic [NUMER_W-1:0] m_numerator   = RST_NUMERATOR;
   logic [LIMIT_W-1:0] m_limit       = RST_LIMIT;
   longint tgt_common = 0;
   longint tgt_diff   = 0;
   longint cur_common = 0;
   longint cur_diff   = 0;

   diff_drive_ramp_step_period dut (.*);

   always #5 clock = ~clock;

   function automatic longint ramp_toward(input longint cur, input longint dst,
                                          input logic [STEP_W-1:0] step);
      longint moved;
      if (cur < dst) begin
         moved = cur + longint'(step);
         return (moved > dst) ? dst : moved;
      end
      if (cur > dst) begin
         moved = cur - longint'(step);
         return (moved < dst) ? dst : moved;
      end
      return cur;
   endfunction

   function automatic logic [PERIOD_W-1:0] period_of(input longint vel);
      longint unsigned mag;
      longint unsigned quot;
      if (vel == 0) return '0;
      mag  = (vel < 0) ? -vel : vel;
      quot = (longint'(m_numerator) << FRACTION_BITS) / mag;
      if (quot > longint'(m_limit)) return '0;
      if (vel < 0) quot = -quot;
      return quot[PERIOD_W-1:0];
   endfunction

   task automatic apply_cmd(input drive_cmd_type cmd);
      longint          a;
      longint          b;
      longint          curv_diff;
      period_pair_type due;
      a = longint'($signed(cmd.value_a));
      b = longint'($signed(cmd.value_b));
      case (cmd.op)
         OP_SET_WHEEL: begin
            tgt_common = (a + b) >>> 1;
            tgt_diff   = (a - b) >>> 1;
         end
         OP_SET_CURV: begin
            curv_diff = (a * b) >>> CURV_SHIFT;
            if (curv_diff > VEL_MAX) curv_diff = VEL_MAX;
            if (curv_diff < VEL_MIN) curv_diff = VEL_MIN;
            tgt_common = a;
            tgt_diff   = curv_diff;
         end
         OP_TICK: begin
            cur_common = ramp_toward(cur_common, tgt_common, m_common_step);
            cur_diff   = ramp_toward(cur_diff, tgt_diff, m_diff_step);
            due.left_period  = period_of(cur_common + cur_diff);
            due.right_period = period_of(cur_common - cur_diff);
            periods_due.push_back(due);
         end
         default: ;
      endcase
   endtask

   task automatic note_failure(input string what, input period_pair_type want,
                               input period_pair_type got);
      failures++;
      if (failures <= 10)
         $display("%0t ns: %s: expected left %0d right %0d, got left %0d right %0d",
                  $time, what, $signed(want.left_period), $signed(want.right_period),
                  $signed(got.left_period), $signed(got.right_period));
   endtask

   // Output words are checked before the accepted command is applied, so a word
   // leaving in the same cycle can never match the expectation of that command.
   always @(posedge clock) begin : monitor
      period_pair_type got;
      period_pair_type want;
      drive_cmd_type   cmd;
      req_fire <= req_tvalid && req_tready;
      if (reset) begin
         tgt_common = 0;
         tgt_diff   = 0;
         cur_common = 0;
         cur_diff   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.left_period  = rsp_tdata[PERIOD_W-1:0];
            got.right_period = rsp_tdata[2*PERIOD_W-1:PERIOD_W];
            if (periods_due.size() == 0) begin
               note_failure("word with nothing expected", '0, got);
            end else begin
               want = periods_due.pop_front();
               if (got.left_period !== want.left_period)
                  note_failure("left_period mismatch", want, got);
               else if (got.right_period !== want.right_period)
                  note_failure("right_period mismatch", want, got);
            end
         end
         if (req_tvalid && req_tready) begin
            cmd.op      = req_tuser;
            cmd.value_a = req_tdata[VAL_W-1:0];
            cmd.value_b = req_tdata[2*VAL_W-1:VAL_W];
            apply_cmd(cmd);
         end
      end
   end

   always @(negedge clock) begin : driver
      drive_cmd_type cmd;
      if (!req_tvalid || req_fire) begin
         if (pending_cmds.size() != 0 &&
             !(idle_en && $urandom_range(99) < IDLE_PERCENT)) begin
            cmd = pending_cmds.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= cmd.op;
            req_tdata  <= {cmd.value_b, cmd.value_a};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= !(idle_en && $urandom_range(99) < IDLE_PERCENT);
   end

   task automatic push_cmd(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] a,
                           input logic [VAL_W-1:0] b);
      drive_cmd_type cmd;
      cmd.op      = op;
      cmd.value_a = a;
      cmd.value_b = b;
      pending_cmds.push_back(cmd);
   endtask

   task automatic write_reg(input csr_index_type idx, input longint unsigned value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      case (idx)
         CSR_COMMON_STEP: m_common_step = value[STEP_W-1:0];
         CSR_DIFF_STEP:   m_diff_step   = value[STEP_W-1:0];
         CSR_NUMERATOR:   m_numerator   = value[NUMER_W-1:0];
         CSR_LIMIT:       m_limit       = value[LIMIT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_config(input longint unsigned common_step,
                               input longint unsigned diff_step,
                               input longint unsigned numerator,
                               input longint unsigned limit);
      write_reg(CSR_COMMON_STEP, common_step);
      write_reg(CSR_DIFF_STEP, diff_step);
      write_reg(CSR_NUMERATOR, numerator);
      write_reg(CSR_LIMIT, limit);
      @(posedge clock);
   endtask

   // Sets cause no word, so a last set may still be in the multiplier when the
   // last word arrives; the settle time covers it before any register write.
   task automatic drain();
      while (pending_cmds.size() != 0 || req_tvalid || periods_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [VAL_W-1:0] rand_speed();
      case ($urandom_range(5))
         0:       return '0;
         1:       return $urandom_range(1) ? VAL_MAX : VAL_MIN;
         2:       return VAL_W'($urandom_range(8192)) - VAL_W'(4096);
         3:       return VAL_W'($urandom_range(262144)) - VAL_W'(131072);
         default: return VAL_W'($urandom());
      endcase
   endfunction

   // Curvature is mostly within +/-2.0 in Q12.12, sometimes anything at all.
   function automatic logic [VAL_W-1:0] rand_curv();
      if ($urandom_range(3) == 0) return rand_speed();
      return VAL_W'($urandom_range(16384)) - VAL_W'(8192);
   endfunction

   function automatic longint unsigned rand_step();
      case ($urandom_range(4))
         0:       return 0;
         1:       return 65535;
         2:       return $urandom_range(255);
         default: return $urandom_range(65535);
      endcase
   endfunction

   task automatic add_random(input int count);
      int n;
      int ticks;
      n = 0;
      while (n < count) begin
         case ($urandom_range(9))
            0: begin
               push_cmd(OP_W'($urandom_range(3)), VAL_W'($urandom()), VAL_W'($urandom()));
               n++;
            end
            1: begin
               push_cmd($urandom_range(1) ? OP_SET_WHEEL : OP_UNUSED,
                        rand_speed(), rand_speed());
               n++;
            end
            default: begin
               if ($urandom_range(1))
                  push_cmd(OP_SET_WHEEL, rand_speed(), rand_speed());
               else
                  push_cmd(OP_SET_CURV, rand_speed(), rand_curv());
               ticks = $urandom_range(24, 1);
               repeat (ticks)
                  push_cmd(OP_TICK, VAL_W'($urandom()), VAL_W'($urandom()));
               n += ticks + 1;
            end
         endcase
      end
   endtask

   initial begin : stimulus
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset register values.
      push_cmd(OP_TICK, '0, '0);
      push_cmd(OP_SET_WHEEL, VAL_MAX, VAL_MAX);
      push_cmd(OP_TICK, VAL_MAX, VAL_MIN);
      push_cmd(OP_TICK, VAL_MIN, VAL_MAX);
      push_cmd(OP_SET_WHEEL, VAL_MIN, VAL_MAX);
      push_cmd(OP_TICK, '0, '0);
      push_cmd(OP_SET_WHEEL, VAL_MIN, VAL_MIN);
      push_cmd(OP_TICK, '0, '0);
      push_cmd(OP_SET_WHEEL, VAL_W'(1), '0);
      push_cmd(OP_TICK, '0, '0);
      push_cmd(OP_SET_WHEEL, VAL_W'(-1), '0);
      push_cmd(OP_TICK, '0, '0);
      push_cmd(OP_SET_CURV, VAL_MAX, VAL_MAX);
      push_cmd(OP_TICK, '0, '0);
      push_cmd(OP_SET_CURV, VAL_MIN, VAL_MAX);
      push_cmd(OP_TICK, '0, '0);
      push_cmd(OP_SET_CURV, VAL_MIN, VAL_MIN);
      push_cmd(OP_TICK, '0, '0);
      push_cmd(OP_SET_CURV, VAL_W'(-300), VAL_W'(-4096));
      push_cmd(OP_TICK, '0, '0);
      push_cmd(OP_UNUSED, VAL_MAX, VAL_MIN);
      push_cmd(OP_TICK, '0, '0);
      drain();

      // Largest values everywhere, with neither side ever idle.
      write_config(65535, 65535, 1073741823, 2147483647);
      idle_en = 1'b0;
      add_random(200);
      drain();
      idle_en = 1'b1;

      // Smallest numerator and limit: every period is forced to zero.
      write_config(0, 65535, 1, 0);
      add_random(100);
      drain();

      // A zero numerator is still writable.
      write_config(rand_step(), rand_step(), 0, $urandom() & 32'h7FFFFFFF);
      add_random(100);
      drain();

      repeat (4) begin
         write_config(rand_step(), rand_step(),
                      $urandom_range(1) ? longint'(RST_NUMERATOR)
                                        : $urandom_range(1073741823),
                      $urandom_range(1) ? longint'($urandom_range(50000000))
                                        : ($urandom() & 32'h7FFFFFFF));
         add_random(150);
         drain();
      end

      if (failures == 0 && periods_due.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : watchdog
      #8_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
